@@ sv/multidim_key_index_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the multi-dimensional key index unit
// Clocked property checks, reset-qualified or checked through reset, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTIDIM_KEY_INDEX_UNIT_DEFINES_SVH
`define MULTIDIM_KEY_INDEX_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define MKIU_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("mkiu check failed");
// checked at every edge, reset included
`define MKIU_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("mkiu check failed");
`else
`define MKIU_ASSERT(label, prop)
`define MKIU_ASSERT_ALWAYS(label, prop)
`endif

`endif

@@ sv/mkiu_pkg.sv @@
// ----------------------------------------------------------------------------
// mkiu_pkg
// Shared constants, codes and pipeline types of the key index unit.
// ----------------------------------------------------------------------------
package mkiu_pkg;

    localparam int MAX_DIMS    = 4;
    localparam int HW_DIMS     = 4;
    localparam int EXTENT_BITS = 12;
    localparam int KEY_W       = 12;
    localparam int EXT_W       = 13;
    localparam int FLAT_W      = 48;
    localparam int CNT_W       = 3;
    localparam int L2_W        = 13;  // extent 3
    localparam int L1_W        = 25;  // extent 2 * extent 3
    localparam int L0_W        = 37;  // extent 1 * extent 2 * extent 3
    localparam int TOT_W       = 49;  // all four extents
    localparam int DIV_STEPS   = HW_DIMS * KEY_W;

    localparam logic [EXT_W-1:0] EXT_TOP    = EXT_W'(1 << EXTENT_BITS);
    localparam logic [CNT_W-1:0] DIMS_LIMIT =
        CNT_W'((MAX_DIMS < HW_DIMS) ? MAX_DIMS : HW_DIMS);

    typedef enum logic [1:0] {
        OP_KEY2IDX  = 2'd0,
        OP_IDX2KEY  = 2'd1,
        OP_VIEW_IDX = 2'd2,
        OP_VIEW_KEY = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_DIM_COUNT = 3'd0,
        REG_EXTENT_0  = 3'd1,
        REG_EXTENT_1  = 3'd2,
        REG_EXTENT_2  = 3'd3,
        REG_EXTENT_3  = 3'd4
    } reg_idx_t;

    typedef logic [EXT_W-1:0] ext_t;
    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        logic [CNT_W-1:0]          dim_count;
        ext_t [HW_DIMS-1:0]        extent;
    } cfg_t;

    typedef struct packed {
        logic [FLAT_W-1:0]         flat;
        key_t [HW_DIMS-1:0]        coords;
        logic [CNT_W-1:0]          count;
        logic                      err;
        logic [1:0]                bad;
    } res_t;

    typedef struct packed {
        logic [FLAT_W-1:0]         rem;
        logic [L0_W-1:0]           len0;
        logic [L1_W-1:0]           len1;
        logic [L2_W-1:0]           len2;
        res_t                      res;
    } div_t;

    // values carried unchanged through the product stages
    typedef struct packed {
        op_t                       op;
        logic [CNT_W-1:0]          n;
        logic                      err;
        logic [1:0]                bad;
        logic [FLAT_W-1:0]         flat_in;
        key_t [HW_DIMS-1:0]        pk;
        logic [CNT_W-1:0]          pk_cnt;
    } carry_t;

    function automatic ext_t clamp_ext(input ext_t e);
        ext_t r;
        r = e;
        if (e == '0) r = EXT_W'(1);
        if (e > EXT_TOP) r = EXT_TOP;
        return r;
    endfunction

endpackage

@@ sv/mkiu_front.sv @@
// ----------------------------------------------------------------------------
// mkiu_front
// Range check, view packing, extent products and Horner flat index,
// five register stages.
// ----------------------------------------------------------------------------
module mkiu_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  mkiu_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    input  mkiu_pkg::op_t                op,
    input  mkiu_pkg::key_t [3:0]         key,
    input  logic [47:0]                  flat_in,
    input  logic [3:0]                   view_mask,
    output logic                         out_valid,
    output mkiu_pkg::div_t               out_data
);
    import mkiu_pkg::*;

    // stage A
    logic                 va_reg;
    carry_t               ca_reg, ca_next;
    ext_t [HW_DIMS-1:0]   ex_reg, ex_next;
    ext_t [HW_DIMS-1:0]   eh_reg, eh_next;
    key_t [HW_DIMS-1:0]   kh_reg, kh_next;
    // stage B
    logic                 vb_reg;
    carry_t               cb_reg;
    ext_t                 exb0_reg, exb1_reg, ehb2_reg, ehb3_reg;
    key_t                 khb2_reg, khb3_reg;
    logic [L2_W-1:0]      lb2_reg;
    logic [L1_W-1:0]      lb1_reg, lb1_next;
    logic [L1_W-1:0]      hb_reg, hb_next;
    // stage C
    logic                 vc_reg;
    carry_t               cc_reg;
    ext_t                 exc0_reg, ehc3_reg;
    key_t                 khc3_reg;
    logic [L2_W-1:0]      lc2_reg;
    logic [L1_W-1:0]      lc1_reg;
    logic [L0_W-1:0]      lc0_reg, lc0_next;
    logic [L0_W-1:0]      hc_reg, hc_next;
    // stage D
    logic                 vd_reg;
    carry_t               cd_reg;
    logic [L2_W-1:0]      ld2_reg;
    logic [L1_W-1:0]      ld1_reg;
    logic [L0_W-1:0]      ld0_reg;
    logic [TOT_W-1:0]     tot_reg, tot_next;
    logic [FLAT_W-1:0]    hd_reg, hd_next;
    // stage E
    logic                 ve_reg;
    div_t                 de_reg, de_next;

    logic [CNT_W-1:0]     n;
    ext_t                 e;
    logic                 inuse, sel;

    always_comb begin
        n = cfg.dim_count;
        if (n == '0) n = CNT_W'(1);
        if (n > DIMS_LIMIT) n = DIMS_LIMIT;
        ca_next = '0;
        ca_next.op = op;
        ca_next.n = n;
        ca_next.flat_in = flat_in;
        ex_next = '0;
        eh_next = '0;
        kh_next = '0;
        e = '0;
        inuse = 1'b0;
        sel = 1'b0;
        for (int i = 0; i < HW_DIMS; i++) begin
            e = clamp_ext(cfg.extent[i]);
            inuse = (CNT_W'(i) < n);
            sel = inuse && (op == OP_KEY2IDX || view_mask[i]);
            ex_next[i] = inuse ? e : EXT_W'(1);
            eh_next[i] = sel ? e : EXT_W'(1);
            kh_next[i] = sel ? key[i] : '0;
            if (op != OP_IDX2KEY && sel && !ca_next.err && {1'b0, key[i]} >= e) begin
                ca_next.err = 1'b1;
                ca_next.bad = 2'(i);
            end
            if (inuse && view_mask[i]) begin
                ca_next.pk[ca_next.pk_cnt[1:0]] = key[i];
                ca_next.pk_cnt = ca_next.pk_cnt + CNT_W'(1);
            end
        end
    end

    assign lb1_next = L1_W'(ex_reg[2]) * L1_W'(ex_reg[3]);
    assign hb_next  = L1_W'(kh_reg[0]) * L1_W'(eh_reg[1]) + L1_W'(kh_reg[1]);
    assign lc0_next = L0_W'(exb1_reg) * L0_W'(lb1_reg);
    assign hc_next  = L0_W'(hb_reg) * L0_W'(ehb2_reg) + L0_W'(khb2_reg);
    assign tot_next = TOT_W'(exc0_reg) * TOT_W'(lc0_reg);
    assign hd_next  = FLAT_W'(hc_reg) * FLAT_W'(ehc3_reg) + FLAT_W'(khc3_reg);

    always_comb begin
        de_next = '0;
        de_next.len0 = ld0_reg;
        de_next.len1 = ld1_reg;
        de_next.len2 = ld2_reg;
        de_next.res.err = cd_reg.err;
        de_next.res.bad = cd_reg.bad;
        if (cd_reg.op == OP_IDX2KEY && {1'b0, cd_reg.flat_in} >= tot_reg) begin
            de_next.res.err = 1'b1;
            de_next.res.bad = 2'd0;
        end
        if (!de_next.res.err) begin
            case (cd_reg.op)
                OP_KEY2IDX, OP_VIEW_IDX: begin
                    de_next.res.flat = hd_reg;
                end
                OP_IDX2KEY: begin
                    // coordinate bits are filled in by the divider steps
                    de_next.rem = cd_reg.flat_in;
                    de_next.res.count = cd_reg.n;
                end
                OP_VIEW_KEY: begin
                    de_next.res.coords = cd_reg.pk;
                    de_next.res.count = cd_reg.pk_cnt;
                end
                default: begin
                    de_next.res.flat = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ca_reg   <= ca_next;
            ex_reg   <= ex_next;
            eh_reg   <= eh_next;
            kh_reg   <= kh_next;
            cb_reg   <= ca_reg;
            exb0_reg <= ex_reg[0];
            exb1_reg <= ex_reg[1];
            ehb2_reg <= eh_reg[2];
            ehb3_reg <= eh_reg[3];
            khb2_reg <= kh_reg[2];
            khb3_reg <= kh_reg[3];
            lb2_reg  <= ex_reg[3];
            lb1_reg  <= lb1_next;
            hb_reg   <= hb_next;
            cc_reg   <= cb_reg;
            exc0_reg <= exb0_reg;
            ehc3_reg <= ehb3_reg;
            khc3_reg <= khb3_reg;
            lc2_reg  <= lb2_reg;
            lc1_reg  <= lb1_reg;
            lc0_reg  <= lc0_next;
            hc_reg   <= hc_next;
            cd_reg   <= cc_reg;
            ld2_reg  <= lc2_reg;
            ld1_reg  <= lc1_reg;
            ld0_reg  <= lc0_reg;
            tot_reg  <= tot_next;
            hd_reg   <= hd_next;
            de_reg   <= de_next;
        end
    end

    assign out_valid = ve_reg;
    assign out_data  = de_reg;

endmodule

@@ sv/mkiu_div_step.sv @@
// ----------------------------------------------------------------------------
// mkiu_div_step
// One restoring division step: one quotient bit of one coordinate.
// ----------------------------------------------------------------------------
module mkiu_div_step (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic [1:0]           digit,
    input  logic [3:0]           bitpos,
    input  logic                 in_valid,
    input  mkiu_pkg::div_t       in_data,
    output logic                 out_valid,
    output mkiu_pkg::div_t       out_data
);
    import mkiu_pkg::*;

    logic                 valid_reg;
    div_t                 data_reg, data_next;
    logic [FLAT_W-1:0]    len, trial;

    always_comb begin
        case (digit)
            2'd0:    len = FLAT_W'(in_data.len0);
            2'd1:    len = FLAT_W'(in_data.len1);
            2'd2:    len = FLAT_W'(in_data.len2);
            default: len = FLAT_W'(1);
        endcase
        trial = len << bitpos;
        data_next = in_data;
        if (in_data.rem >= trial) begin
            data_next.rem = in_data.rem - trial;
            data_next.res.coords[digit][bitpos] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ sv/multidim_key_index_unit.sv @@
// Pipeline: 5 front stages, then 48 divider steps.
// Throughput: one request per cycle; the whole pipeline holds while the
// result is not taken.
// The index-to-key divider resolves one quotient bit per stage.
// Reset: synchronous active-low aresetn clears valid bits and sets
// dim_count and all extents to 1.
// ----------------------------------------------------------------------------
// multidim_key_index_unit
// Row-major key/flat index conversion with view mask, streaming top level.
// ----------------------------------------------------------------------------
`include "multidim_key_index_unit_defines.svh"

module multidim_key_index_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [12:0]   cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    // operation[1:0], key_0[13:2], key_1[25:14], key_2[37:26], key_3[49:38],
    // flat_in[97:50], view_mask[101:98], zero pad[103:102]
    input  logic [103:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // flat_out[47:0], coord_0[59:48], coord_1[71:60], coord_2[83:72],
    // coord_3[95:84], coord_count[98:96], range_error[99], bad_dim[101:100],
    // zero pad[103:102]
    output logic [103:0]  m_tdata
);
    import mkiu_pkg::*;

    logic                   en;
    cfg_t                   cfg_reg;
    logic                   dv [0:DIV_STEPS];
    div_t                   dd [0:DIV_STEPS];
    res_t                   res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dim_count <= CNT_W'(1);
            for (int i = 0; i < HW_DIMS; i++) cfg_reg.extent[i] <= EXT_W'(1);
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_DIM_COUNT: cfg_reg.dim_count <= cfg_wdata[CNT_W-1:0];
                REG_EXTENT_0:  cfg_reg.extent[0] <= cfg_wdata;
                REG_EXTENT_1:  cfg_reg.extent[1] <= cfg_wdata;
                REG_EXTENT_2:  cfg_reg.extent[2] <= cfg_wdata;
                REG_EXTENT_3:  cfg_reg.extent[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    mkiu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .op        (op_t'(s_tdata[1:0])),
        .key       ({s_tdata[49:38], s_tdata[37:26], s_tdata[25:14], s_tdata[13:2]}),
        .flat_in   (s_tdata[97:50]),
        .view_mask (s_tdata[101:98]),
        .out_valid (dv[0]),
        .out_data  (dd[0])
    );

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        localparam logic [1:0] DIGIT = 2'(g / KEY_W);
        localparam logic [3:0] BITP  = 4'(KEY_W - 1 - (g % KEY_W));
        mkiu_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .digit     (DIGIT),
            .bitpos    (BITP),
            .in_valid  (dv[g]),
            .in_data   (dd[g]),
            .out_valid (dv[g+1]),
            .out_data  (dd[g+1])
        );
    end

    assign res      = dd[DIV_STEPS].res;
    assign m_tvalid = dv[DIV_STEPS];
    assign m_tdata  = {2'b00, res.bad, res.err, res.count,
                       res.coords[3], res.coords[2], res.coords[1], res.coords[0],
                       res.flat};

    `MKIU_ASSERT(a_err_clears, m_tvalid && res.err |-> res.flat == '0 && res.count == '0)
    `MKIU_ASSERT(a_bad_only_on_err, m_tvalid && !res.err |-> res.bad == 2'd0)
    `MKIU_ASSERT(a_flat_or_key, m_tvalid && res.count != '0 |-> res.flat == '0)
    `MKIU_ASSERT_ALWAYS(a_count_range, m_tvalid |-> res.count <= CNT_W'(HW_DIMS))

endmodule

@@ dv/multidim_key_index_unit_tb.sv @@
// ----------------------------------------------------------------------------
// multidim_key_index_unit_tb
// Drives key/index conversion requests under several dimension and extent
// settings, predicts each result in a local model and checks field by field.
// ----------------------------------------------------------------------------
module multidim_key_index_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mkiu_pkg::*;

    localparam int LATENCY    = 53;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [47:0] flat;
        logic [11:0] c0, c1, c2, c3;
        logic [2:0]  count;
        logic        err;
        logic [1:0]  bad;
    } addr_res_t;

    logic          aclk;
    logic          aresetn;
    logic          cfg_we;
    logic [2:0]    cfg_index;
    logic [12:0]   cfg_wdata;
    logic          s_tvalid;
    logic          s_tready;
    logic [103:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [103:0]  m_tdata;

    logic [2:0]    cur_dims;
    logic [12:0]   cur_ext [4];
    addr_res_t     pending_q [$];
    int            fail_cnt;
    int            idle_cycles = 0;
    bit            rx_pause;

    multidim_key_index_unit dut (.*);

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    function automatic int used_dims();
        int n;
        n = cur_dims;
        if (n < 1) n = 1;
        if (n > MAX_DIMS) n = MAX_DIMS;
        if (n > 4) n = 4;
        return n;
    endfunction

    function automatic longint unsigned eff_extent(int i);
        longint unsigned e;
        e = cur_ext[i];
        if (e == 0) e = 1;
        if (e > (64'd1 << EXTENT_BITS)) e = 64'd1 << EXTENT_BITS;
        return e;
    endfunction

    function automatic addr_res_t predict_address(op_t op, logic [11:0] key [4],
                                                  logic [47:0] flat, logic [3:0] mask);
        addr_res_t r;
        int n, cnt;
        bit err;
        logic [1:0] bad;
        longint unsigned acc, off, total, rem, len;
        logic [11:0] co [4];
        n = used_dims();
        err = 0; bad = 0; acc = 0; cnt = 0;
        co = '{default: '0};
        if (op != OP_IDX2KEY) begin
            for (int i = 0; i < n; i++) begin
                if ((op == OP_KEY2IDX || mask[i]) && key[i] >= eff_extent(i)) begin
                    err = 1; bad = i[1:0];
                    break;
                end
            end
        end
        if (!err) begin
            case (op)
                OP_KEY2IDX, OP_VIEW_IDX: begin
                    for (int i = 0; i < n; i++) begin
                        if (op == OP_VIEW_IDX && !mask[i]) continue;
                        off = 1;
                        for (int j = i + 1; j < n; j++)
                            if (op == OP_KEY2IDX || mask[j]) off *= eff_extent(j);
                        acc += key[i] * off;
                    end
                end
                OP_IDX2KEY: begin
                    total = 1;
                    for (int i = 0; i < n; i++) total *= eff_extent(i);
                    if (flat >= total) begin
                        err = 1; bad = 0;
                    end else begin
                        rem = flat;
                        for (int i = 0; i < n; i++) begin
                            len = 1;
                            for (int j = i + 1; j < n; j++) len *= eff_extent(j);
                            co[i] = 12'(rem / len);
                            rem = rem % len;
                        end
                        cnt = n;
                    end
                end
                default: begin
                    for (int i = 0; i < n; i++)
                        if (mask[i]) begin
                            co[cnt] = key[i];
                            cnt++;
                        end
                end
            endcase
        end
        if (err) begin
            acc = 0; cnt = 0; co = '{default: '0};
        end
        r.flat = acc[47:0];
        r.c0 = co[0]; r.c1 = co[1]; r.c2 = co[2]; r.c3 = co[3];
        r.count = cnt[2:0];
        r.err = err;
        r.bad = err ? bad : 2'd0;
        return r;
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [12:0] val);
        @(negedge aclk);
        cfg_we = 1'b1; cfg_index = idx; cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == REG_DIM_COUNT) cur_dims = val[2:0];
        else cur_ext[idx - 1] = val;
    endtask

    task automatic set_shape(logic [2:0] dims, logic [12:0] e0, logic [12:0] e1,
                             logic [12:0] e2, logic [12:0] e3);
        wait (pending_q.size() == 0);
        repeat (LATENCY + 5) @(negedge aclk);
        write_reg(REG_DIM_COUNT, {10'd0, dims});
        write_reg(REG_EXTENT_0, e0);
        write_reg(REG_EXTENT_1, e1);
        write_reg(REG_EXTENT_2, e2);
        write_reg(REG_EXTENT_3, e3);
    endtask

    // send one request; called at a falling edge
    task automatic send_request(op_t op, logic [11:0] k0, logic [11:0] k1,
                                logic [11:0] k2, logic [11:0] k3,
                                logic [47:0] flat, logic [3:0] mask);
        logic [11:0] key [4];
        int gap;
        key = '{k0, k1, k2, k3};
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge aclk);
        s_tdata = {2'b00, mask, flat, k3, k2, k1, k0, op};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_q.insert(pending_q.size(), predict_address(op, key, flat, mask));
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    function automatic logic [11:0] pick_key(int i);
        longint unsigned e;
        e = eff_extent(i);
        case ($urandom_range(0, 9))
            0: return 12'($urandom);
            1: return 12'(e - 1);
            2: return 12'(e);
            default: return 12'($urandom_range(0, int'(e - 1)));
        endcase
    endfunction

    function automatic logic [47:0] pick_flat();
        longint unsigned total;
        total = 1;
        for (int i = 0; i < used_dims(); i++) total *= eff_extent(i);
        case ($urandom_range(0, 9))
            0: return 48'({$urandom, $urandom});
            1: return 48'(total - 1);
            2: return 48'(total);
            default: return 48'({$urandom, $urandom} % total);
        endcase
    endfunction

    task automatic send_random(int count);
        for (int k = 0; k < count; k++)
            send_request(op_t'($urandom_range(0, 3)), pick_key(0), pick_key(1),
                         pick_key(2), pick_key(3), pick_flat(), 4'($urandom));
    endtask

    task automatic test_reset_shape();
        send_request(OP_KEY2IDX, 12'd0, 12'd0, 12'd0, 12'd0, 48'd0, 4'h0);
        send_request(OP_KEY2IDX, 12'd1, 12'd0, 12'd0, 12'd0, 48'd0, 4'h0);
        send_request(OP_IDX2KEY, 12'd0, 12'd0, 12'd0, 12'd0, 48'd1, 4'h0);
    endtask

    task automatic test_directed_extremes();
        set_shape(3'd4, 13'd4096, 13'd4096, 13'd4096, 13'd4096);
        send_request(OP_KEY2IDX, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 48'd0, 4'h0);
        send_request(OP_IDX2KEY, 12'd0, 12'd0, 12'd0, 12'd0, 48'hffff_ffff_ffff, 4'h0);
        send_request(OP_IDX2KEY, 12'd0, 12'd0, 12'd0, 12'd0, 48'h0, 4'h0);
        send_request(OP_VIEW_IDX, 12'hfff, 12'h0, 12'hfff, 12'h0, 48'd0, 4'b0101);
        send_request(OP_VIEW_KEY, 12'h0, 12'hfff, 12'h0, 12'hfff, 48'd0, 4'b1010);
        send_request(OP_VIEW_KEY, 12'h5a5, 12'ha5a, 12'h123, 12'h321, 48'd0, 4'hf);
        // clamped extents: zero acts as one, above 4096 acts as 4096
        set_shape(3'd7, 13'd0, 13'd8191, 13'd5, 13'd4097);
        send_request(OP_KEY2IDX, 12'd0, 12'hfff, 12'd4, 12'hfff, 48'd0, 4'h0);
        send_request(OP_KEY2IDX, 12'd1, 12'd0, 12'd9, 12'd0, 48'd0, 4'h0);
        send_request(OP_KEY2IDX, 12'd0, 12'd0, 12'd9, 12'd0, 48'd0, 4'h0);
        send_request(OP_IDX2KEY, 12'd0, 12'd0, 12'd0, 12'd0, 48'd83886079, 4'h0);
        send_request(OP_IDX2KEY, 12'd0, 12'd0, 12'd0, 12'd0, 48'd83886080, 4'h0);
        send_request(OP_VIEW_IDX, 12'd7, 12'd3, 12'd9, 12'd2, 48'd0, 4'b1010);
        send_request(OP_VIEW_KEY, 12'd7, 12'd3, 12'd9, 12'd2, 48'd0, 4'b0100);
        // dim count zero acts as one; mask bits past it ignored
        set_shape(3'd0, 13'd10, 13'd1, 13'd1, 13'd1);
        send_request(OP_VIEW_KEY, 12'd3, 12'hfff, 12'hfff, 12'hfff, 48'd0, 4'hf);
        send_request(OP_VIEW_IDX, 12'd10, 12'd0, 12'd0, 12'd0, 48'd0, 4'he);
        send_request(OP_IDX2KEY, 12'd0, 12'd0, 12'd0, 12'd0, 48'd10, 4'h0);
    endtask

    task automatic test_random_shapes();
        logic [12:0] e [4];
        for (int p = 0; p < 12; p++) begin
            for (int i = 0; i < 4; i++)
                case ($urandom_range(0, 5))
                    0: e[i] = 13'd4096;
                    1: e[i] = 13'd1;
                    2: e[i] = 13'($urandom);
                    default: e[i] = 13'($urandom_range(1, 40));
                endcase
            set_shape(3'($urandom_range(0, 7)), e[0], e[1], e[2], e[3]);
            send_random(90);
        end
    endtask

    task automatic test_drain_pause();
        set_shape(3'd3, 13'd7, 13'd13, 13'd3, 13'd1);
        send_random(10);
        wait (pending_q.size() == 0);
        @(negedge aclk);
        send_random(10);
    endtask

    // result side
    initial begin
        m_tready = 1'b0;
        rx_pause = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_pause) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 9)) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            rx_pause = 1'b0;
            if (m_tvalid) begin
                addr_res_t got, want;
                got = {m_tdata[47:0], m_tdata[59:48], m_tdata[71:60], m_tdata[83:72],
                       m_tdata[95:84], m_tdata[98:96], m_tdata[99], m_tdata[101:100]};
                rx_pause = ($urandom_range(0, 2) == 0);
                if (pending_q.size() == 0) begin
                    $error("result with nothing expected: %h", m_tdata);
                    fail_cnt++;
                end else begin
                    want = pending_q.pop_front();
                    if (got.flat != want.flat) begin
                        $error("flat_out exp %0d got %0d", want.flat, got.flat); fail_cnt++;
                    end
                    if (got.c0 != want.c0) begin
                        $error("coord_0 exp %0d got %0d", want.c0, got.c0); fail_cnt++;
                    end
                    if (got.c1 != want.c1) begin
                        $error("coord_1 exp %0d got %0d", want.c1, got.c1); fail_cnt++;
                    end
                    if (got.c2 != want.c2) begin
                        $error("coord_2 exp %0d got %0d", want.c2, got.c2); fail_cnt++;
                    end
                    if (got.c3 != want.c3) begin
                        $error("coord_3 exp %0d got %0d", want.c3, got.c3); fail_cnt++;
                    end
                    if (got.count != want.count) begin
                        $error("coord_count exp %0d got %0d", want.count, got.count);
                        fail_cnt++;
                    end
                    if (got.err != want.err) begin
                        $error("range_error exp %0d got %0d", want.err, got.err);
                        fail_cnt++;
                    end
                    if (got.bad != want.bad) begin
                        $error("bad_dim exp %0d got %0d", want.bad, got.bad); fail_cnt++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any request or result moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("multidim_key_index_unit verification failed");
            $finish;
        end
    end

    initial begin
        fail_cnt = 0;
        aresetn = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
        s_tvalid = 1'b0; s_tdata = '0;
        cur_dims = 3'd1;
        cur_ext = '{default: 13'd1};
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_reset_shape();
        test_directed_extremes();
        test_drain_pause();
        test_random_shapes();
        wait (pending_q.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (fail_cnt == 0 && pending_q.size() == 0) begin
            $display("multidim_key_index_unit verification clean");
        end else begin
            $display("multidim_key_index_unit verification failed");
        end
        $finish;
    end
endmodule
